// File: rtl/multi_level_priority_queue_top_defines.svh
// Assertion macros for the multi-level priority queue.
// Used by multi_level_priority_queue_top; no other dependencies.
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define MLPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MLPQ_ASSERT_NR(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MLPQ_ASSERT(name, prop, msg)
`define MLPQ_ASSERT_NR(name, prop, msg)
`endif

`endif

// File: rtl/mlpq_pkg.sv
// Shared types and constants for the multi-level priority queue.
// No dependencies.
`default_nettype none

package mlpq_pkg;

  localparam int LevelsDef     = 8;
  localparam int SlotsDef      = 16;
  localparam int ValueWidthDef = 32;

  localparam int          LiuW     = 4;
  localparam logic [3:0]  LiuReset = 4'd8;

  typedef enum logic {
    KIND_INSERT,
    KIND_REMOVE
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_OVERFLOW,
    ST_UNDERFLOW,
    ST_BADLEVEL
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_EXEC,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
    logic [2:0]         level;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic [2:0]         removed_level;
  } rsp_t;

  typedef struct packed {
    logic       en;
    kind_e      kind;
    logic [2:0] level;
  } cmd_t;

  typedef struct packed {
    status_e    status;
    logic [2:0] level;
  } lvl_res_t;

endpackage

`default_nettype wire

// File: rtl/mlpq_slot_mem.sv
// Single-port slot storage with registered read data.
// Depends on nothing.
`default_nettype none

module mlpq_slot_mem #(
  parameter int Depth = 128,
  parameter int Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/mlpq_level_unit.sv
// Per-level head/tail pointers, non-empty flags, level select and pointer update.
// Depends on mlpq_pkg.
`default_nettype none

module mlpq_level_unit #(
  parameter int Levels = 8,
  parameter int Slots  = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mlpq_pkg::cmd_t                    cmd_i,
  input  wire logic [mlpq_pkg::LiuW-1:0]         active_i,
  output mlpq_pkg::lvl_res_t                     res_o,
  output logic                                   mem_we_o,
  output logic                                   mem_re_o,
  output logic [$clog2(Levels*Slots)-1:0]        mem_addr_o
);

  import mlpq_pkg::*;

  localparam int          LvlW     = $clog2(Levels);
  localparam int          PtrW     = $clog2(Slots);
  localparam int          AddrW    = $clog2(Levels*Slots);
  localparam logic [31:0] LevelsU  = 32'(Levels);
  localparam logic [PtrW-1:0] SlotLast = PtrW'(Slots - 1);

  logic [PtrW-1:0]   head_q [Levels];
  logic [PtrW-1:0]   head_d [Levels];
  logic [PtrW-1:0]   tail_q [Levels];
  logic [PtrW-1:0]   tail_d [Levels];
  logic [Levels-1:0] nonempty_q, nonempty_d;

  logic [Levels-1:0] cand;
  logic              found;
  logic [LvlW-1:0]   enc_lv;
  logic              ins_ok;
  logic [LvlW-1:0]   sel_lv;
  logic [PtrW-1:0]   ptr;
  logic [PtrW-1:0]   sel_head, sel_tail;
  logic              sel_ne;
  status_e           status;

  always_comb begin
    for (int i = 0; i < Levels; i++) begin
      cand[i] = nonempty_q[i] && (32'(i) < 32'(active_i));
    end
  end

  always_comb begin
    found  = 1'b0;
    enc_lv = '0;
    for (int i = Levels - 1; i >= 0; i--) begin
      if (cand[i]) begin
        found  = 1'b1;
        enc_lv = LvlW'(i);
      end
    end
  end

  assign ins_ok = (32'(cmd_i.level) < 32'(active_i)) && (32'(cmd_i.level) < LevelsU);
  assign sel_lv = (cmd_i.kind == KIND_INSERT) ? LvlW'(cmd_i.level) : enc_lv;
  assign sel_head = head_q[sel_lv];
  assign sel_tail = tail_q[sel_lv];
  assign sel_ne   = nonempty_q[sel_lv];

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    nonempty_d = nonempty_q;
    status     = ST_OK;
    mem_we_o   = 1'b0;
    mem_re_o   = 1'b0;
    ptr        = '0;
    if (cmd_i.en) begin
      if (cmd_i.kind == KIND_INSERT) begin
        if (!ins_ok) begin
          status = ST_BADLEVEL;
        end else if (!sel_ne) begin
          head_d[sel_lv]     = '0;
          tail_d[sel_lv]     = '0;
          nonempty_d[sel_lv] = 1'b1;
          mem_we_o           = 1'b1;
        end else if (sel_tail == SlotLast) begin
          status = ST_OVERFLOW;
        end else begin
          tail_d[sel_lv] = sel_tail + 1'b1;
          ptr            = sel_tail + 1'b1;
          mem_we_o       = 1'b1;
        end
      end else begin
        if (!found) begin
          status = ST_UNDERFLOW;
        end else begin
          ptr      = sel_head;
          mem_re_o = 1'b1;
          if (sel_head >= sel_tail) begin
            nonempty_d[sel_lv] = 1'b0;
            head_d[sel_lv]     = '0;
            tail_d[sel_lv]     = '0;
          end else begin
            head_d[sel_lv] = sel_head + 1'b1;
          end
        end
      end
    end
  end

  assign mem_addr_o   = AddrW'(sel_lv) * AddrW'(Slots) + AddrW'(ptr);
  assign res_o.status = status;
  assign res_o.level  = 3'(sel_lv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q <= '0;
      for (int i = 0; i < Levels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      nonempty_q <= nonempty_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/multi_level_priority_queue_top.sv
// Top level of the multi-level priority queue: sequencer, config register, result regs.
// Depends on mlpq_pkg, mlpq_level_unit, mlpq_slot_mem and the defines header.
//
// For each request, busy is high for the one cycle in which the level unit selects
// the level and updates its pointers while the slot memory is written or read; the
// next cycle shows the result on rsp_o with done_o high for exactly one cycle, fed by
// the registered read of the slot memory. A new request may be taken in that result
// cycle. The result cannot be held off, so the receiver must take it when done_o is
// high. levels_in_use may only be written while no request is in flight.
`default_nettype none
`include "multi_level_priority_queue_top_defines.svh"

module multi_level_priority_queue_top #(
  parameter int LEVELS      = mlpq_pkg::LevelsDef,
  parameter int SLOTS       = mlpq_pkg::SlotsDef,
  parameter int VALUE_WIDTH = mlpq_pkg::ValueWidthDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire mlpq_pkg::req_t            req_i,
  output logic                           done_o,
  output mlpq_pkg::rsp_t                 rsp_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [mlpq_pkg::LiuW-1:0] cfg_wdata_i
);

  import mlpq_pkg::*;

  localparam int AddrW = $clog2(LEVELS*SLOTS);

  fsm_e            state_q, state_d;
  logic [LiuW-1:0] liu_q;
  req_t            req_q;
  status_e         status_q;
  logic [2:0]      lvl_q;

  cmd_t                   cmd;
  lvl_res_t               lvl_res;
  logic                   mem_we, mem_re;
  logic [AddrW-1:0]       mem_addr;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   accept;
  logic                   rem_ok;

  assign accept = start && !busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (accept) state_d = FSM_EXEC;
      FSM_EXEC: state_d = FSM_RESP;
      FSM_RESP: state_d = accept ? FSM_EXEC : FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b0;
    done_o    = 1'b0;
    cmd.en    = 1'b0;
    cmd.kind  = req_q.kind;
    cmd.level = req_q.level;
    case (state_q)
      FSM_EXEC: begin
        busy   = 1'b1;
        cmd.en = 1'b1;
      end
      FSM_RESP: done_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      liu_q   <= LiuReset;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        liu_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == FSM_EXEC) begin
      status_q <= lvl_res.status;
      lvl_q    <= lvl_res.level;
    end
  end

  mlpq_level_unit #(
    .Levels (LEVELS),
    .Slots  (SLOTS)
  ) u_level (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .active_i   (liu_q),
    .res_o      (lvl_res),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr)
  );

  mlpq_slot_mem #(
    .Depth (LEVELS*SLOTS),
    .Width (VALUE_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (VALUE_WIDTH'($unsigned(req_q.value))),
    .rdata_o (mem_rdata)
  );

  assign rem_ok              = (req_q.kind == KIND_REMOVE) && (status_q == ST_OK);
  assign rsp_o.status        = status_q;
  assign rsp_o.removed_value = rem_ok ? $signed(32'(mem_rdata)) : '0;
  assign rsp_o.removed_level = rem_ok ? lvl_q : '0;

  `MLPQ_ASSERT(a_done_one_cycle, done_o |=> !done_o, "result strobe held past one cycle")
  `MLPQ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not start work")
  `MLPQ_ASSERT(a_busy_done, busy |=> done_o, "request finished without a result")
  `MLPQ_ASSERT(a_fail_zero,
    (done_o && (rsp_o.status != ST_OK)) |-> (rsp_o.removed_value == '0 && rsp_o.removed_level == '0),
    "failed request returned data")

endmodule

`default_nettype wire

// File: test/tb_multi_level_priority_queue_top.sv
// Self-checking testbench for multi_level_priority_queue_top: directed corner tests, then
// random insert/remove traffic, sender idle or not, checked by an inline queue model.
// Depends on mlpq_pkg and the RTL of multi_level_priority_queue_top.
module tb_multi_level_priority_queue_top;
  import mlpq_pkg::*;

  localparam int StallLimit = 1000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_drv;
  logic done;
  rsp_t rsp_mon;
  logic cfg_we;
  logic [LiuW-1:0] cfg_wdata;

  // queue model state
  logic [31:0] slot_data [LevelsDef][SlotsDef];
  int head_ptr [LevelsDef];
  int tail_ptr [LevelsDef];
  bit occupied [LevelsDef];
  logic [LiuW-1:0] levels_cfg;

  rsp_t expected_responses [$];
  int failures;
  int idle_cycles;
  int sender_idle_pct;

  multi_level_priority_queue_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_drv),
    .done_o     (done),
    .rsp_o      (rsp_mon),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int active_level_count();
    return (levels_cfg > LevelsDef) ? LevelsDef : int'(levels_cfg);
  endfunction

  function automatic rsp_t predict_response(req_t r);
    rsp_t res;
    int active;
    int lv;
    bit found;
    res = '0;
    active = active_level_count();
    if (r.kind == KIND_INSERT) begin
      lv = r.level;
      if (lv >= active) begin
        res.status = ST_BADLEVEL;
      end else if (!occupied[lv]) begin
        head_ptr[lv] = 0;
        tail_ptr[lv] = 0;
        occupied[lv] = 1'b1;
        slot_data[lv][0] = r.value;
      end else if (tail_ptr[lv] >= SlotsDef - 1) begin
        res.status = ST_OVERFLOW;
      end else begin
        tail_ptr[lv]++;
        slot_data[lv][tail_ptr[lv]] = r.value;
      end
    end else begin
      res.status = ST_UNDERFLOW;
      found = 1'b0;
      for (lv = 0; lv < active; lv++) begin
        if (!found && occupied[lv]) begin
          found = 1'b1;
          res.status = ST_OK;
          res.removed_value = slot_data[lv][head_ptr[lv]];
          res.removed_level = lv[2:0];
          if (head_ptr[lv] >= tail_ptr[lv]) begin
            occupied[lv] = 1'b0;
            head_ptr[lv] = 0;
            tail_ptr[lv] = 0;
          end else begin
            head_ptr[lv]++;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic req_t make_req(kind_e k, logic [31:0] v, logic [2:0] lv);
    req_t r;
    r.kind = k;
    r.value = v;
    r.level = lv;
    return r;
  endfunction

  // called at a rising edge; returns at a rising edge with start possibly still high
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req_drv <= r;
    do @(posedge clk_i); while (busy);
    expected_responses.push_back(predict_response(r));
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_responses.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_levels(input logic [LiuW-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    levels_cfg = v;
    cfg_we <= 1'b0;
  endtask

  task automatic test_empty_remove();
    send_request(make_req(KIND_REMOVE, 32'h0, 3'd0));
  endtask

  // level 7 is left full and used later by the register tests
  task automatic test_full_level();
    int i;
    logic [31:0] v;
    for (i = 0; i < SlotsDef; i++) begin
      v = (i == 0) ? 32'h7fff_ffff : (i == 1) ? 32'h8000_0000 : $urandom;
      send_request(make_req(KIND_INSERT, v, 3'd7));
    end
    send_request(make_req(KIND_INSERT, 32'hffff_ffff, 3'd7));
  endtask

  task automatic test_priority_order();
    send_request(make_req(KIND_INSERT, 32'hffff_ffff, 3'd0));
    send_request(make_req(KIND_REMOVE, 32'hffff_ffff, 3'd7));
  endtask

  task automatic test_level_register();
    drain_responses();
    write_levels(4'd0);
    send_request(make_req(KIND_INSERT, 32'h1, 3'd0));
    send_request(make_req(KIND_REMOVE, 32'h0, 3'd0));
    drain_responses();
    write_levels(4'd15);
    drain_responses();
    write_levels(4'd1);
    send_request(make_req(KIND_REMOVE, 32'h0, 3'd0));
    send_request(make_req(KIND_INSERT, 32'h5a5a_a5a5, 3'd1));
    drain_responses();
    write_levels(4'd8);
    send_request(make_req(KIND_REMOVE, 32'h0, 3'd0));
  endtask

  task automatic run_random_traffic(input int count, input int pct_idle,
                                    input logic [LiuW-1:0] first_cfg);
    int i;
    int insert_pct;
    int n;
    req_t r;
    drain_responses();
    write_levels(first_cfg);
    sender_idle_pct = pct_idle;
    insert_pct = 70;
    for (i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // hold off until no response is outstanding, then move the level limit
        drain_responses();
        case ($urandom_range(3))
          0: write_levels(4'd1);
          1: write_levels(4'd2);
          2: write_levels(4'd3);
          default: write_levels(4'($urandom_range(15)));
        endcase
      end
      if (i % 32 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 90;
          1: insert_pct = 70;
          default: insert_pct = 25;
        endcase
      end
      r.kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
      case ($urandom_range(9))
        0: r.value = 32'h7fff_ffff;
        1: r.value = 32'h8000_0000;
        2: r.value = 32'hffff_ffff;
        3: r.value = 32'h0;
        default: r.value = $urandom;
      endcase
      n = active_level_count();
      if (n == 0 || $urandom_range(9) == 0) r.level = 3'($urandom_range(7));
      else r.level = 3'($urandom_range(n - 1, 0));
      send_request(r);
    end
    drain_responses();
  endtask

  always @(posedge clk_i) begin : check_responses
    rsp_t want;
    if (rst_ni && done) begin
      if (expected_responses.size() == 0) begin
        $error("response with no request outstanding: %p", rsp_mon);
        failures++;
      end else begin
        want = expected_responses.pop_front();
        if (rsp_mon.status !== want.status) begin
          $error("status: expected %s actual %s", want.status.name(), rsp_mon.status.name());
          failures++;
        end
        if (rsp_mon.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d actual %0d",
                 want.removed_value, rsp_mon.removed_value);
          failures++;
        end
        if (rsp_mon.removed_level !== want.removed_level) begin
          $error("removed_level: expected %0d actual %0d",
                 want.removed_level, rsp_mon.removed_level);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $error("no request or response for %0d cycles", StallLimit);
      $display("multi_level_priority_queue_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    failures = 0;
    idle_cycles = 0;
    sender_idle_pct = 0;
    levels_cfg = LiuReset;
    foreach (occupied[i]) begin
      occupied[i] = 1'b0;
      head_ptr[i] = 0;
      tail_ptr[i] = 0;
    end
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_drv <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_remove();
    test_full_level();
    test_priority_order();
    test_level_register();
    run_random_traffic(500, 28, 4'd2);
    run_random_traffic(500, 64, 4'd8);
    run_random_traffic(500, 0, 4'($urandom_range(15)));

    drain_responses();
    repeat (4) @(posedge clk_i);
    if (failures == 0) begin
      $display("multi_level_priority_queue_top regression: pass");
    end else begin
      $display("multi_level_priority_queue_top regression: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl
rtl/mlpq_pkg.sv
rtl/mlpq_slot_mem.sv
rtl/mlpq_level_unit.sv
rtl/multi_level_priority_queue_top.sv
test/tb_multi_level_priority_queue_top.sv
